// File: rtl/core/fm_register_to_midi_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// fm register to midi tracker assertion macros
// shared property shorthands for the tracker's concurrent checks
// ----------------------------------------------------------------------------
`ifndef FM_REGISTER_TO_MIDI_TRACKER_TOP_DEFINES_SVH
`define FM_REGISTER_TO_MIDI_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FM2M_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fm2m same-cycle check failed");

// next-cycle implication, checked outside reset
`define FM2M_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fm2m next-cycle check failed");

`endif

// File: rtl/core/fm2m_pkg.sv
// ----------------------------------------------------------------------------
// fm2m package
// shared types, codes, constant tables and the pitch boundary rom
// ----------------------------------------------------------------------------
`default_nettype none

package fm2m_pkg;

    // patch table geometry
    localparam int PATCH_SLOTS = 256;
    localparam int PATCH_IDX_W = (PATCH_SLOTS > 1) ? $clog2(PATCH_SLOTS) : 1;

    // configuration port
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_EN   = 2'd1;

    // input action codes
    localparam logic [2:0] ACT_REG_WRITE  = 3'd0;
    localparam logic [2:0] ACT_PATCH_LOAD = 3'd1;
    localparam logic [2:0] ACT_RESET      = 3'd2;
    localparam logic [2:0] ACT_PANIC      = 3'd3;
    localparam logic [2:0] ACT_NEW_SONG   = 3'd4;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_REG_WRITE,
        CMD_PATCH_LOAD,
        CMD_RESET,
        CMD_PANIC,
        CMD_NEW_SONG
    } cmd_t;

    typedef enum logic [1:0] {
        EV_NOTE_OFF = 2'd0,
        EV_NOTE_ON  = 2'd1,
        EV_PROGRAM  = 2'd2,
        EV_ALL_OFF  = 2'd3
    } ev_kind_t;

    // midi and synth constants
    localparam logic [6:0] ALL_NOTES_OFF_CC = 7'd123;
    localparam logic [6:0] DEFAULT_VELOCITY = 7'd100;
    localparam logic [6:0] MAX_MIDI_VALUE   = 7'd127;
    localparam logic [3:0] DRUM_CHANNEL     = 4'd9;
    localparam logic [3:0] LAST_CHANNEL     = 4'd15;
    localparam int         NUM_VOICES       = 9;
    localparam logic [7:0] KEY_REG_FIRST    = 8'hb0;
    localparam logic [7:0] KEY_REG_LAST     = 8'hb8;
    localparam logic [7:0] FNUM_LO_BASE     = 8'ha0;
    localparam logic [7:0] FEEDBACK_BASE    = 8'hc0;
    localparam int         KEY_ON_BIT       = 5;

    // operator offset of each voice
    localparam logic [7:0] OPOFF [NUM_VOICES] = '{
        8'h00, 8'h01, 8'h02, 8'h08, 8'h09, 8'h0a, 8'h10, 8'h11, 8'h12};

    // modulator then carrier register bases of the fingerprint bytes
    localparam logic [7:0] OP_BASE [8] = '{
        8'h20, 8'h60, 8'h80, 8'he0, 8'h23, 8'h63, 8'h83, 8'he3};

    // 2^(j/24) for odd j, scaled by 10^10
    localparam logic [63:0] HALFSTEP [12] = '{
        64'd10293022366, 64'd10905077327, 64'd11553526969, 64'd12240535433,
        64'd12968395547, 64'd13739536475, 64'd14556531828, 64'd15422108254,
        64'd16339154532, 64'd17310731220, 64'd18340080864, 64'd19430638823};

    localparam logic [63:0] BND_DEN = 64'd12429 * 64'd9765625;

    typedef logic [31:0] bnd_tab_t [128];

    // note boundary n with 8 fraction bits, evaluated at elaboration
    function automatic logic [31:0] bnd_calc(input int n);
        int          e;
        int          q;
        int          j;
        logic [63:0] num;
        e   = 2 * n + 5;
        q   = e / 24;
        j   = e % 24;
        num = (64'd110 * HALFSTEP[j >> 1]) << (12 + q);
        return 32'((num + BND_DEN / 2) / BND_DEN);
    endfunction

    function automatic bnd_tab_t bnd_build();
        bnd_tab_t t;
        for (int n = 0; n < 128; n++)
        begin
            t[n] = (n == 0) ? 32'd0 : bnd_calc(n);
        end
        return t;
    endfunction

    localparam bnd_tab_t BND_TAB = bnd_build();

    // shadow address of fetch step k for voice v
    function automatic logic [7:0] fetch_addr(input logic [3:0] v, input logic [3:0] k);
        logic [7:0] a;
        if (k < 4'd8)
            a = OP_BASE[k[2:0]] + OPOFF[v];
        else if (k == 4'd8)
            a = FEEDBACK_BASE + {4'd0, v};
        else
            a = FNUM_LO_BASE + {4'd0, v};
        return a;
    endfunction

    // classified item between front and back
    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  reg_addr;
        logic [7:0]  reg_value;
        logic [7:0]  patch_slot;
        logic [63:0] patch_op_bytes;
        logic [7:0]  patch_feedback;
        logic [7:0]  patch_instrument;
        logic [7:0]  patch_velocity;
        logic [7:0]  patch_transpose;
    } q_item_t;

    typedef struct packed {
        logic init_busy;
        logic busy;
    } back_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/fm_register_to_midi_tracker_top.sv
// ----------------------------------------------------------------------------
// fm register to midi tracker top
// turns fm synth register writes into midi note and program events
// ----------------------------------------------------------------------------
// After reset the block zeroes its 256-entry register shadow with
// s_axis_tready low; a reset action repeats that sweep after its 16 beats
// but without holding s_axis_tready low. A plain register write passes ST_KEY
// in the back end; a patch load is written as it is popped. A key-on searches
// the patch slots (up to patch_count, at most 256): the scan reads one slot
// a cycle from the patch memories, and the pitch search is a binary search of
// the boundary rom. Beats then leave at one per cycle while m_axis_tready is
// high. A two-item queue lets the next items in while one is worked on.
`default_nettype none

`include "fm_register_to_midi_tracker_top_defines.svh"

module fm_register_to_midi_tracker_top
    import fm2m_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // reg_addr, reg_value, patch_slot, patch_op_bytes, patch_feedback,
    // patch_instrument, patch_velocity, patch_transpose
    input  logic [119:0]          s_axis_tdata,
    // action
    input  logic [2:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // midi_channel, first_data, second_data, zero pad
    output logic [23:0]           m_axis_tdata,
    // event_kind
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] patch_count_reg;
    logic                  output_en_reg;
    q_item_t               q_head;
    logic                  q_valid;
    logic                  q_pop;
    back_stat_t            stat;
    ev_kind_t              out_kind;
    logic [3:0]            out_chan;
    logic [6:0]            out_d1;
    logic [6:0]            out_d2;
    logic                  init_busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_count_reg <= '0;
            output_en_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATCH_COUNT: patch_count_reg <= cfg_data;
                REG_OUTPUT_EN:   output_en_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    fm2m_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (stat.init_busy),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_head   (q_head),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    fm2m_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_head         (q_head),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .patch_count    (patch_count_reg),
        .output_enabled (output_en_reg),
        .stat           (stat),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_kind       (out_kind),
        .out_chan       (out_chan),
        .out_d1         (out_d1),
        .out_d2         (out_d2),
        .out_last       (m_axis_tlast)
    );

    // output beat packing
    assign m_axis_tdata = {6'd0, out_d2, out_d1, out_chan};
    assign m_axis_tuser = out_kind;
    assign init_busy    = stat.init_busy;

    // checks
    `FM2M_ASSERT_IMP(a_no_accept_in_init, init_busy, !s_axis_tready)
    `FM2M_ASSERT_IMP(a_all_off_cc, m_axis_tvalid && (out_kind == EV_ALL_OFF), out_d1 == ALL_NOTES_OFF_CC)
    `FM2M_ASSERT_IMP(a_note_on_vel, m_axis_tvalid && (out_kind == EV_NOTE_ON), out_d2 != 7'd0)
    `FM2M_ASSERT_IMP(a_pop_only_idle, q_pop, !stat.busy)
    `FM2M_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

`default_nettype wire

// File: rtl/core/fm2m_ram.sv
// ----------------------------------------------------------------------------
// fm2m generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fm2m_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/fm2m_front.sv
// ----------------------------------------------------------------------------
// fm2m front end
// accepts input beats, classifies the action and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module fm2m_front
    import fm2m_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         hold,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic [2:0]   s_tuser,
    output q_item_t      q_head,
    output logic         q_valid,
    input  logic         q_pop
);

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    q_item_t    item;
    logic       push;

    // classify the action
    always_comb
    begin
        item                  = '0;
        item.reg_addr         = s_tdata[7:0];
        item.reg_value        = s_tdata[15:8];
        item.patch_slot       = s_tdata[23:16];
        item.patch_op_bytes   = s_tdata[87:24];
        item.patch_feedback   = s_tdata[95:88];
        item.patch_instrument = s_tdata[103:96];
        item.patch_velocity   = s_tdata[111:104];
        item.patch_transpose  = s_tdata[119:112];
        unique case (s_tuser)
            ACT_REG_WRITE:  item.cmd = CMD_REG_WRITE;
            ACT_PATCH_LOAD: item.cmd = CMD_PATCH_LOAD;
            ACT_RESET:      item.cmd = CMD_RESET;
            ACT_PANIC:      item.cmd = CMD_PANIC;
            ACT_NEW_SONG:   item.cmd = CMD_NEW_SONG;
            default:        item.cmd = CMD_NONE;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_head   = mem_reg[rd_ptr_reg];

    // two-entry queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !q_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (q_pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fm2m_back.sv
// ----------------------------------------------------------------------------
// fm2m back end
// register shadow, patch search, pitch search and event sequencing
// ----------------------------------------------------------------------------
`default_nettype none

module fm2m_back
    import fm2m_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_item_t               q_head,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic [CFG_DATA_W-1:0] patch_count,
    input  logic                  output_enabled,
    output back_stat_t            stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ev_kind_t              out_kind,
    output logic [3:0]            out_chan,
    output logic [6:0]            out_d1,
    output logic [6:0]            out_d2,
    output logic                  out_last
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_FETCH,
        ST_SCAN,
        ST_DECIDE,
        ST_PITCH,
        ST_FINAL,
        ST_EMIT,
        ST_ALL_OFF
    } state_t;

    state_t                  state_reg;
    logic                    init_busy_reg;
    logic [7:0]              clr_cnt_reg;
    logic [7:0]              addr_reg;
    logic [7:0]              val_reg;
    logic [3:0]              voice_reg;
    logic [3:0]              fetch_cnt_reg;
    logic [63:0]             fp_reg;
    logic [7:0]              fb_reg;
    logic [7:0]              a0_reg;
    logic [CFG_DATA_W-1:0]   scan_idx_reg;
    logic                    cmp_pend_reg;
    logic                    found_reg;
    logic [31:0]             attr_reg;
    logic [24:0]             x_reg;
    logic [2:0]              pb_reg;
    logic [6:0]              note_reg;
    logic [3:0]              ch_reg;
    logic [6:0]              vel_reg;
    logic                    upd_rel_reg;
    logic                    upd_prog_reg;
    logic                    upd_on_reg;
    logic                    pend_rel_reg;
    logic                    pend_prog_reg;
    logic                    pend_on_reg;
    logic [3:0]              ano_cnt_reg;
    logic                    is_reset_reg;
    logic                    v_active_reg [NUM_VOICES];
    logic [3:0]              v_chan_reg [NUM_VOICES];
    logic [6:0]              v_note_reg [NUM_VOICES];
    logic                    pc_valid_reg [16];
    logic [7:0]              pc_prog_reg [16];
    logic                    out_valid_reg;
    ev_kind_t                out_kind_reg;
    logic [3:0]              out_chan_reg;
    logic [6:0]              out_d1_reg;
    logic [6:0]              out_d2_reg;
    logic                    out_last_reg;

    logic                    sh_we;
    logic [7:0]              sh_waddr;
    logic [7:0]              sh_wdata;
    logic [7:0]              sh_raddr;
    logic [7:0]              sh_rdata;
    logic                    pt_we;
    logic [63:0]             fp_rdata;
    logic [31:0]             attr_rdata;
    logic                    slot_ok;
    logic [CFG_DATA_W-1:0]   limit;
    logic                    out_free;
    logic                    beat_load;
    logic                    key_hit;
    logic [3:0]              fetch_k;
    logic [7:0]              inst;
    logic [7:0]              velo;
    logic [6:0]              vel_sel;
    logic [9:0]              fnum;
    logic [6:0]              cand;
    logic signed [9:0]       tsum;
    logic [6:0]              tnote;
    logic                    prog_need;

    // shadow and patch memories
    fm2m_ram #(.WIDTH(8), .DEPTH(256)) u_shadow (
        .clk   (clk),
        .we    (sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .raddr (sh_raddr),
        .rdata (sh_rdata)
    );

    fm2m_ram #(.WIDTH(64), .DEPTH(PATCH_SLOTS)) u_fp (
        .clk   (clk),
        .we    (pt_we),
        .waddr (q_head.patch_slot[PATCH_IDX_W-1:0]),
        .wdata (q_head.patch_op_bytes),
        .raddr (scan_idx_reg[PATCH_IDX_W-1:0]),
        .rdata (fp_rdata)
    );

    fm2m_ram #(.WIDTH(32), .DEPTH(PATCH_SLOTS)) u_attr (
        .clk   (clk),
        .we    (pt_we),
        .waddr (q_head.patch_slot[PATCH_IDX_W-1:0]),
        .wdata ({q_head.patch_transpose, q_head.patch_velocity,
                 q_head.patch_instrument, q_head.patch_feedback}),
        .raddr (scan_idx_reg[PATCH_IDX_W-1:0]),
        .rdata (attr_rdata)
    );

    // memory port control
    assign slot_ok  = {1'b0, q_head.patch_slot} < CFG_DATA_W'(PATCH_SLOTS);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign pt_we    = q_pop && (q_head.cmd == CMD_PATCH_LOAD) && slot_ok;
    assign sh_we    = (state_reg == ST_CLEAR) || (state_reg == ST_KEY);
    assign sh_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign sh_wdata = (state_reg == ST_CLEAR) ? 8'd0 : val_reg;
    assign sh_raddr = (state_reg == ST_FETCH) ? fetch_addr(voice_reg, fetch_cnt_reg)
                                              : q_head.reg_addr;

    // decode helpers
    assign limit    = (patch_count > CFG_DATA_W'(PATCH_SLOTS)) ? CFG_DATA_W'(PATCH_SLOTS)
                                                                : patch_count;
    assign out_free = !out_valid_reg || out_ready;
    assign key_hit  = (addr_reg >= KEY_REG_FIRST) && (addr_reg <= KEY_REG_LAST);
    assign fetch_k  = fetch_cnt_reg - 4'd1;
    assign inst     = attr_reg[15:8];
    assign velo     = attr_reg[23:16];
    assign vel_sel  = (velo == 8'd0) ? DEFAULT_VELOCITY
                    : (velo[7] ? MAX_MIDI_VALUE : velo[6:0]);
    assign fnum     = {val_reg[1:0], a0_reg};
    assign cand     = note_reg | (7'd1 << pb_reg);

    // a beat enters the output register this cycle
    assign beat_load = out_free &&
                       (((state_reg == ST_EMIT) &&
                         (pend_rel_reg || pend_prog_reg || pend_on_reg)) ||
                        (state_reg == ST_ALL_OFF));

    // transpose with clamp and program cache check
    always_comb
    begin
        tsum = $signed({3'd0, note_reg}) + $signed({{2{attr_reg[31]}}, attr_reg[31:24]});
        if (tsum < 10'sd0)
            tnote = 7'd0;
        else if (tsum > 10'sd127)
            tnote = MAX_MIDI_VALUE;
        else
            tnote = tsum[6:0];
        prog_need = !pc_valid_reg[voice_reg] || (pc_prog_reg[voice_reg] != inst);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            init_busy_reg <= 1'b1;
            clr_cnt_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
            pend_rel_reg  <= 1'b0;
            pend_prog_reg <= 1'b0;
            pend_on_reg   <= 1'b0;
            cmp_pend_reg  <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                v_active_reg[i] <= 1'b0;
                v_chan_reg[i]   <= 4'd0;
                v_note_reg[i]   <= 7'd0;
            end
            for (int i = 0; i < 16; i++)
            begin
                pc_valid_reg[i] <= 1'b0;
                pc_prog_reg[i]  <= 8'd0;
            end
        end
        else
        begin
            if (out_ready && !beat_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                // zero the shadow one entry a cycle
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 8'd1;
                    if (clr_cnt_reg == 8'hff)
                    begin
                        init_busy_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                // take the next item
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        addr_reg     <= q_head.reg_addr;
                        val_reg      <= q_head.reg_value;
                        is_reset_reg <= (q_head.cmd == CMD_RESET);
                        ano_cnt_reg  <= 4'd0;
                        case (q_head.cmd)
                            CMD_REG_WRITE:
                                state_reg <= ST_KEY;
                            CMD_RESET, CMD_PANIC:
                                state_reg <= ST_ALL_OFF;
                            CMD_NEW_SONG:
                            begin
                                for (int i = 0; i < NUM_VOICES; i++)
                                    v_active_reg[i] <= 1'b0;
                                for (int i = 0; i < 16; i++)
                                    pc_valid_reg[i] <= 1'b0;
                            end
                            default:
                                state_reg <= ST_IDLE;
                        endcase
                    end
                end

                // shadow write and key edge detect
                ST_KEY:
                begin
                    voice_reg     <= addr_reg[3:0];
                    fetch_cnt_reg <= 4'd0;
                    upd_rel_reg   <= v_active_reg[addr_reg[3:0]];
                    pend_rel_reg  <= v_active_reg[addr_reg[3:0]] && output_enabled;
                    upd_prog_reg  <= 1'b0;
                    upd_on_reg    <= 1'b0;
                    pend_prog_reg <= 1'b0;
                    pend_on_reg   <= 1'b0;
                    if (key_hit && val_reg[KEY_ON_BIT] && !sh_rdata[KEY_ON_BIT])
                        state_reg <= ST_FETCH;
                    else if (key_hit && !val_reg[KEY_ON_BIT] && sh_rdata[KEY_ON_BIT])
                        state_reg <= ST_EMIT;
                    else
                        state_reg <= ST_IDLE;
                end

                // read operator bytes, feedback and fnum low from the shadow
                ST_FETCH:
                begin
                    fetch_cnt_reg <= fetch_cnt_reg + 4'd1;
                    if (fetch_cnt_reg != 4'd0)
                    begin
                        if (fetch_k < 4'd8)
                            fp_reg[{fetch_k[2:0], 3'b000} +: 8] <= sh_rdata;
                        else if (fetch_k == 4'd8)
                            fb_reg <= sh_rdata;
                        else
                            a0_reg <= sh_rdata;
                    end
                    if (fetch_cnt_reg == 4'd10)
                    begin
                        scan_idx_reg <= '0;
                        cmp_pend_reg <= 1'b0;
                        found_reg    <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end

                // first-hit search over the patch table
                ST_SCAN:
                begin
                    if (cmp_pend_reg && (fp_rdata == fp_reg) && (attr_rdata[7:0] == fb_reg))
                    begin
                        found_reg    <= 1'b1;
                        attr_reg     <= attr_rdata;
                        cmp_pend_reg <= 1'b0;
                        state_reg    <= ST_DECIDE;
                    end
                    else if (scan_idx_reg < limit)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        cmp_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        cmp_pend_reg <= 1'b0;
                        if (!cmp_pend_reg)
                        begin
                            attr_reg  <= '0;
                            state_reg <= ST_DECIDE;
                        end
                    end
                end

                // drum, silent or melodic
                ST_DECIDE:
                begin
                    x_reg  <= {17'(fnum) << val_reg[4:2], 8'd0};
                    pb_reg <= 3'd6;
                    if (found_reg && inst[7])
                    begin
                        ch_reg      <= DRUM_CHANNEL;
                        note_reg    <= inst[6:0];
                        vel_reg     <= vel_sel;
                        upd_on_reg  <= 1'b1;
                        pend_on_reg <= output_enabled;
                        state_reg   <= ST_EMIT;
                    end
                    else
                    begin
                        note_reg <= 7'd0;
                        if (fnum == 10'd0)
                            state_reg <= ST_EMIT;
                        else
                            state_reg <= ST_PITCH;
                    end
                end

                // binary search of the boundary rom, one bit a cycle
                ST_PITCH:
                begin
                    if ({7'd0, x_reg} >= BND_TAB[cand])
                        note_reg <= cand;
                    pb_reg <= pb_reg - 3'd1;
                    if (pb_reg == 3'd0)
                        state_reg <= ST_FINAL;
                end

                // melodic note, velocity and program change
                ST_FINAL:
                begin
                    ch_reg      <= voice_reg;
                    upd_on_reg  <= 1'b1;
                    pend_on_reg <= output_enabled;
                    if (found_reg)
                    begin
                        note_reg      <= tnote;
                        vel_reg       <= vel_sel;
                        upd_prog_reg  <= prog_need;
                        pend_prog_reg <= prog_need && output_enabled;
                    end
                    else
                        vel_reg <= DEFAULT_VELOCITY;
                    state_reg <= ST_EMIT;
                end

                // send pending beats, then commit voice and program state
                ST_EMIT:
                begin
                    if (pend_rel_reg || pend_prog_reg || pend_on_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            if (pend_rel_reg)
                            begin
                                out_kind_reg <= EV_NOTE_OFF;
                                out_chan_reg <= v_chan_reg[voice_reg];
                                out_d1_reg   <= v_note_reg[voice_reg];
                                out_d2_reg   <= 7'd0;
                                out_last_reg <= !(pend_prog_reg || pend_on_reg);
                                pend_rel_reg <= 1'b0;
                            end
                            else if (pend_prog_reg)
                            begin
                                out_kind_reg  <= EV_PROGRAM;
                                out_chan_reg  <= ch_reg;
                                out_d1_reg    <= inst[6:0];
                                out_d2_reg    <= 7'd0;
                                out_last_reg  <= !pend_on_reg;
                                pend_prog_reg <= 1'b0;
                            end
                            else
                            begin
                                out_kind_reg <= EV_NOTE_ON;
                                out_chan_reg <= ch_reg;
                                out_d1_reg   <= note_reg;
                                out_d2_reg   <= vel_reg;
                                out_last_reg <= 1'b1;
                                pend_on_reg  <= 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        if (upd_on_reg)
                        begin
                            v_active_reg[voice_reg] <= 1'b1;
                            v_chan_reg[voice_reg]   <= ch_reg;
                            v_note_reg[voice_reg]   <= note_reg;
                        end
                        else if (upd_rel_reg)
                            v_active_reg[voice_reg] <= 1'b0;
                        if (upd_prog_reg)
                        begin
                            pc_valid_reg[voice_reg] <= 1'b1;
                            pc_prog_reg[voice_reg]  <= inst;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                // all notes off on every channel
                ST_ALL_OFF:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= EV_ALL_OFF;
                        out_chan_reg  <= ano_cnt_reg;
                        out_d1_reg    <= ALL_NOTES_OFF_CC;
                        out_d2_reg    <= 7'd0;
                        out_last_reg  <= (ano_cnt_reg == LAST_CHANNEL);
                        ano_cnt_reg   <= ano_cnt_reg + 4'd1;
                        if (ano_cnt_reg == LAST_CHANNEL)
                        begin
                            for (int i = 0; i < NUM_VOICES; i++)
                                v_active_reg[i] <= 1'b0;
                            if (is_reset_reg)
                            begin
                                for (int i = 0; i < 16; i++)
                                    pc_valid_reg[i] <= 1'b0;
                                clr_cnt_reg <= 8'd0;
                                state_reg   <= ST_CLEAR;
                            end
                            else
                                state_reg <= ST_IDLE;
                        end
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign stat.init_busy = init_busy_reg;
    assign stat.busy      = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_chan       = out_chan_reg;
    assign out_d1         = out_d1_reg;
    assign out_d2         = out_d2_reg;
    assign out_last       = out_last_reg;

endmodule

`default_nettype wire
